### hw/rtl/plc_pkg.sv
// ============================================================================
// Power limit controller package
// Shared widths, codes, reset values and types of the power limit controller.
// ============================================================================
package plc_pkg;

    localparam int REQ_W      = 3;
    localparam int POWER_W    = 24;
    localparam int DUR_W      = 32;
    localparam int SET_W      = 32;
    localparam int MODE_W     = 3;
    localparam int HB_W       = 16;
    localparam int LPC_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_TICK        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_HEARTBEAT   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LIMIT       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FS_DURATION = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FS_LIMIT    = 3'd4;

    // Operating modes.
    localparam logic [MODE_W-1:0] MODE_INIT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LIMITED  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UNL_CTRL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UNL_AUTO = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAILSAFE = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HB_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LPC_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_DURATION = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_LIMIT    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [HB_W-1:0]    HB_TIMEOUT_RST  = 16'd60;
    localparam logic [LPC_W-1:0]   LPC_TIMEOUT_RST = 16'd120;
    localparam logic [DUR_W-1:0]   FS_DURATION_RST = 32'd7200;
    localparam logic [POWER_W-1:0] FS_LIMIT_RST    = 24'd0;

    localparam logic [POWER_W-1:0] POWER_MAX = '1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic               limit_active;
        logic [POWER_W-1:0] limit_value;
        logic [DUR_W-1:0]   limit_duration;
        logic               limit_delete_duration;
        logic [SET_W-1:0]   new_setting;
    } t_plc_req;

    // Conditions that drive the mode decision.
    typedef struct packed {
        logic hb_lost;
        logic active;
        logic deactivated;
        logic expired;
        logic init_timeout;
        logic fs_exit;
        logic limit_since_fs;
    } t_plc_cond;

endpackage

### hw/rtl/plc_ifs.sv
// ============================================================================
// Power limit controller channels
// Valid/ready channels for requests, results and configuration writes.
// ============================================================================
interface plc_req_if;
    logic                         valid;
    logic                         ready;
    logic [plc_pkg::REQ_W-1:0]    req_type;
    logic                         limit_active;
    logic [plc_pkg::POWER_W-1:0]  limit_value;
    logic [plc_pkg::DUR_W-1:0]    limit_duration;
    logic                         limit_delete_duration;
    logic [plc_pkg::SET_W-1:0]    new_setting;

    modport source (output valid, req_type, limit_active, limit_value, limit_duration,
                    limit_delete_duration, new_setting, input ready);
    modport sink (input valid, req_type, limit_active, limit_value, limit_duration,
                  limit_delete_duration, new_setting, output ready);
endinterface

interface plc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [plc_pkg::MODE_W-1:0]   mode;
    logic                         apply_valid;
    logic                         apply_active;
    logic [plc_pkg::POWER_W-1:0]  apply_value;

    modport source (output valid, mode, apply_valid, apply_active, apply_value,
                    input ready);
    modport sink (input valid, mode, apply_valid, apply_active, apply_value,
                  output ready);
endinterface

interface plc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [plc_pkg::CFG_IDX_W-1:0]   index;
    logic [plc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/plc_mode_sel.sv
// ============================================================================
// Power limit controller mode selection
// Next-mode decision from the current mode and the evaluated conditions.
// ============================================================================
module plc_mode_sel (
    input  logic [plc_pkg::MODE_W-1:0] i_mode,
    input  plc_pkg::t_plc_cond         i_cond,
    output logic [plc_pkg::MODE_W-1:0] o_mode
);
    import plc_pkg::*;

    always_comb begin
        o_mode = i_mode;
        unique case (i_mode)
            MODE_LIMITED: begin
                if (i_cond.hb_lost) begin
                    o_mode = MODE_FAILSAFE;
                end else if (i_cond.deactivated || i_cond.expired) begin
                    o_mode = MODE_UNL_CTRL;
                end
            end
            MODE_UNL_CTRL: begin
                if (i_cond.hb_lost) begin
                    o_mode = MODE_FAILSAFE;
                end else if (i_cond.active) begin
                    o_mode = MODE_LIMITED;
                end
            end
            MODE_UNL_AUTO: begin
                if (i_cond.hb_lost) begin
                    o_mode = MODE_FAILSAFE;
                end else if (i_cond.deactivated || i_cond.expired) begin
                    o_mode = MODE_UNL_CTRL;
                end else if (i_cond.active) begin
                    o_mode = MODE_LIMITED;
                end
            end
            MODE_FAILSAFE: begin
                // Failsafe is held while heartbeats are missing. A fresh limit
                // leaves it at once, otherwise the exit timeout does.
                if (!i_cond.hb_lost) begin
                    if (i_cond.limit_since_fs) begin
                        if (i_cond.active) begin
                            o_mode = MODE_LIMITED;
                        end else if (i_cond.deactivated) begin
                            o_mode = MODE_UNL_CTRL;
                        end
                    end else if (i_cond.fs_exit) begin
                        o_mode = MODE_UNL_AUTO;
                    end
                end
            end
            default: begin
                o_mode = MODE_INIT;
                if (i_cond.hb_lost) begin
                    o_mode = MODE_FAILSAFE;
                end else if (i_cond.init_timeout) begin
                    o_mode = MODE_UNL_AUTO;
                end else if (i_cond.active) begin
                    o_mode = MODE_LIMITED;
                end else if (i_cond.deactivated) begin
                    o_mode = MODE_UNL_CTRL;
                end
            end
        endcase
    end

endmodule

### hw/rtl/power_limit_control_fsm.sv
// ============================================================================
// Power limit control state machine
// Five-mode power consumption limit controller driven by one event per
// transaction: tick, heartbeat, limit update or failsafe setting update.
// ============================================================================
// Flow: an accepted request is loaded into the input register, and its result
// is loaded into the result register when the input register is processed.
// Throughput: one request per cycle while results are taken; a result held by
// the sink stalls the input register. The decision is a single compare pass.
// Reset (synchronous, active low) puts the controller in init mode with all
// timestamps zero and the configuration registers at their default values.
module power_limit_control_fsm #(
    parameter int TIME_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plc_req_if.sink   i_req,
    plc_cfg_if.sink   i_cfg,
    plc_rsp_if.source o_rsp
);
    import plc_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > DUR_W + 1) ? TIME_WIDTH : DUR_W + 1;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    // Input register.
    logic     r_in_valid;
    t_plc_req r_in;
    logic     proc_fire;

    // Configuration.
    logic [HB_W-1:0]  r_hb_timeout;
    logic [LPC_W-1:0] r_lpc_timeout;

    // Controller state.
    logic [MODE_W-1:0]     r_mode;
    logic [TIME_WIDTH-1:0] r_now, n_now;
    logic [TIME_WIDTH-1:0] r_hb_time, n_hb_time;
    logic [TIME_WIDTH-1:0] r_limit_time, n_limit_time;
    logic [TIME_WIDTH-1:0] r_fs_entry, n_fs_entry;
    logic                  r_lpresent, n_lpresent;
    logic                  r_sactive, n_sactive;
    logic [POWER_W-1:0]    r_svalue, n_svalue;
    logic [DUR_W-1:0]      r_sduration, n_sduration;
    logic                  r_sno_expiry, n_sno_expiry;
    logic                  r_lsf, n_lsf;
    logic [DUR_W-1:0]      r_fs_duration, n_fs_duration;
    logic [POWER_W-1:0]    r_fs_limit, n_fs_limit;

    logic                  limit_changed;
    logic [MODE_W-1:0]     cur_mode;
    logic [MODE_W-1:0]     n_mode;
    t_plc_cond             cond;
    logic                  mode_changed;
    logic                  n_apply_valid;
    logic                  n_apply_active;
    logic [POWER_W-1:0]    n_apply_value;

    // Result register.
    logic               r_out_valid;
    logic [MODE_W-1:0]  r_out_mode;
    logic               r_out_apply_valid;
    logic               r_out_apply_active;
    logic [POWER_W-1:0] r_out_apply_value;

    assign proc_fire   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || proc_fire;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.req_type              <= i_req.req_type;
            r_in.limit_active          <= i_req.limit_active;
            r_in.limit_value           <= i_req.limit_value;
            r_in.limit_duration        <= i_req.limit_duration;
            r_in.limit_delete_duration <= i_req.limit_delete_duration;
            r_in.new_setting           <= i_req.new_setting;
        end
    end

    // Apply the event to the state, then evaluate the rules on the result.
    always_comb begin
        n_now         = r_now;
        n_hb_time     = r_hb_time;
        n_limit_time  = r_limit_time;
        n_lpresent    = r_lpresent;
        n_sactive     = r_sactive;
        n_svalue      = r_svalue;
        n_sduration   = r_sduration;
        n_sno_expiry  = r_sno_expiry;
        n_fs_duration = r_fs_duration;
        n_fs_limit    = r_fs_limit;
        limit_changed = 1'b0;
        case (r_in.req_type)
            REQ_TICK: begin
                if (r_now != TIME_MAX) begin
                    n_now = r_now + TIME_WIDTH'(1);
                end
            end
            REQ_HEARTBEAT: begin
                n_hb_time = r_now;
            end
            REQ_LIMIT: begin
                n_lpresent    = 1'b1;
                n_sactive     = r_in.limit_active;
                n_svalue      = r_in.limit_value;
                n_sduration   = r_in.limit_duration;
                n_sno_expiry  = r_in.limit_delete_duration;
                n_limit_time  = r_now;
                limit_changed = 1'b1;
            end
            REQ_FS_DURATION: begin
                n_fs_duration = r_in.new_setting;
            end
            REQ_FS_LIMIT: begin
                if (r_in.new_setting > SET_W'(POWER_MAX)) begin
                    n_fs_limit = POWER_MAX;
                end else begin
                    n_fs_limit = r_in.new_setting[POWER_W-1:0];
                end
            end
            default: ;
        endcase

        cond.hb_lost = CMP_W'(n_now - n_hb_time) > CMP_W'(r_hb_timeout);
        cond.active = n_lpresent && n_sactive;
        cond.deactivated = n_lpresent && !n_sactive;
        cond.expired = n_lpresent && !n_sno_expiry && (n_sduration != '0) &&
                       (CMP_W'(n_now - n_limit_time) >= CMP_W'(n_sduration));
        cond.init_timeout = CMP_W'(n_now) > CMP_W'(r_lpc_timeout);
        cond.fs_exit = CMP_W'(n_now - r_fs_entry) >
                       (CMP_W'(n_fs_duration) + CMP_W'(r_lpc_timeout));
        cond.limit_since_fs = limit_changed || r_lsf;

        // An unknown mode code reads as init without counting as a change.
        cur_mode = (r_mode > MODE_FAILSAFE) ? MODE_INIT : r_mode;
    end

    plc_mode_sel u_mode_sel (
        .i_mode (cur_mode),
        .i_cond (cond),
        .o_mode (n_mode)
    );

    always_comb begin
        mode_changed = (n_mode != cur_mode);
        n_fs_entry   = r_fs_entry;
        n_lsf        = cond.limit_since_fs;
        if (mode_changed && (n_mode == MODE_FAILSAFE)) begin
            n_fs_entry = n_now;
            n_lsf      = 1'b0;
        end

        n_apply_valid  = mode_changed || limit_changed;
        n_apply_active = 1'b0;
        n_apply_value  = '0;
        if (n_apply_valid) begin
            if ((n_mode == MODE_LIMITED) && n_lpresent) begin
                n_apply_active = n_sactive;
                n_apply_value  = n_svalue;
            end else if (n_mode == MODE_FAILSAFE) begin
                n_apply_active = 1'b1;
                n_apply_value  = n_fs_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_timeout  <= HB_TIMEOUT_RST;
            r_lpc_timeout <= LPC_TIMEOUT_RST;
            r_mode        <= MODE_INIT;
            r_now         <= '0;
            r_hb_time     <= '0;
            r_limit_time  <= '0;
            r_fs_entry    <= '0;
            r_lpresent    <= 1'b0;
            r_sactive     <= 1'b0;
            r_svalue      <= '0;
            r_sduration   <= '0;
            r_sno_expiry  <= 1'b0;
            r_lsf         <= 1'b0;
            r_fs_duration <= FS_DURATION_RST;
            r_fs_limit    <= FS_LIMIT_RST;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_HB_TIMEOUT:  r_hb_timeout  <= i_cfg.data[HB_W-1:0];
                    CFG_LPC_TIMEOUT: r_lpc_timeout <= i_cfg.data[LPC_W-1:0];
                    CFG_FS_DURATION: r_fs_duration <= i_cfg.data[DUR_W-1:0];
                    CFG_FS_LIMIT:    r_fs_limit    <= i_cfg.data[POWER_W-1:0];
                    default: ;
                endcase
            end
            if (proc_fire) begin
                r_mode        <= n_mode;
                r_now         <= n_now;
                r_hb_time     <= n_hb_time;
                r_limit_time  <= n_limit_time;
                r_fs_entry    <= n_fs_entry;
                r_lpresent    <= n_lpresent;
                r_sactive     <= n_sactive;
                r_svalue      <= n_svalue;
                r_sduration   <= n_sduration;
                r_sno_expiry  <= n_sno_expiry;
                r_lsf         <= n_lsf;
                r_fs_duration <= n_fs_duration;
                r_fs_limit    <= n_fs_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_mode         <= n_mode;
            r_out_apply_valid  <= n_apply_valid;
            r_out_apply_active <= n_apply_active;
            r_out_apply_value  <= n_apply_value;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.mode         = r_out_mode;
    assign o_rsp.apply_valid  = r_out_apply_valid;
    assign o_rsp.apply_active = r_out_apply_active;
    assign o_rsp.apply_value  = r_out_apply_value;

    a_apply_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_apply_valid |-> !r_out_apply_active && (r_out_apply_value == '0))
        else $error("apply fields set without a mode or limit change");

    a_fs_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_apply_valid && (r_out_mode == MODE_FAILSAFE) |-> r_out_apply_active)
        else $error("failsafe result without an active limit");

    a_fs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && mode_changed && (n_mode == MODE_FAILSAFE)
        |=> (r_fs_entry == $past(n_now)) && !r_lsf)
        else $error("failsafe entry did not record its time");

    a_now_monotonic: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) |-> r_now >= $past(r_now))
        else $error("tick counter went backwards");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc_fire |=> r_in_valid && $stable(r_in))
        else $error("pending request lost from the input register");

endmodule
